[rtl/serial_can_frame_deframer_defines.svh]
// Assertion macros shared by the serial CAN frame deframer.
`ifndef SERIAL_CAN_FRAME_DEFRAMER_DEFINES_SVH
`define SERIAL_CAN_FRAME_DEFRAMER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCFD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/scfd_pkg.sv]
// Shared types and constants of the serial CAN frame deframer.
package scfd_pkg;

    localparam int ID_W      = 12;
    localparam int LEN_W     = 4;
    localparam int DATA_W    = 64;
    localparam int BYTE_W    = 8;
    localparam int HITS_W    = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 12;

    localparam int NUM_FILTERS_DEF    = 4;
    localparam int MAX_DATA_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH_DEF    = 2;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'hFD;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'hBF;

    localparam logic [ID_W-1:0] MASK_RESET  = 12'h000;
    localparam logic [ID_W-1:0] MATCH_RESET = 12'h001;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_LEN   = 3'd1,
        PH_IDLO  = 3'd2,
        PH_DATA  = 3'd3,
        PH_END   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] data;
    } frame_t;

    // Push side of the frame queue as seen from the parser.
    typedef struct packed {
        logic   push;
        frame_t frame;
    } frame_push_t;

endpackage

[rtl/scfd_parser.sv]
// Byte parser: walks the frame format and emits each completed frame.
module scfd_parser #(
    parameter int MAX_DATA_BYTES = scfd_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [scfd_pkg::BYTE_W-1:0] rx_byte,
    output scfd_pkg::frame_push_t       out
);

    scfd_pkg::phase_t                 phase_reg, phase_next;
    logic [scfd_pkg::LEN_W-1:0]       bytes_left_reg, bytes_left_next;
    logic [scfd_pkg::ID_W-1:0]        id_reg, id_next;
    logic [scfd_pkg::LEN_W-1:0]       length_reg, length_next;
    logic [scfd_pkg::DATA_W-1:0]      data_reg, data_next;
    logic [2:0]                       pos;
    logic [scfd_pkg::LEN_W-1:0]       len_nibble;
    logic                             len_bad;

    assign len_nibble = rx_byte[7:4];
    assign len_bad    = len_nibble > scfd_pkg::LEN_W'(MAX_DATA_BYTES);
    assign pos        = 3'(length_reg - bytes_left_reg);

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                scfd_pkg::PH_LEN:
                    phase_next = len_bad ? scfd_pkg::PH_START : scfd_pkg::PH_IDLO;
                scfd_pkg::PH_IDLO:
                    phase_next = (length_reg == '0) ? scfd_pkg::PH_END : scfd_pkg::PH_DATA;
                scfd_pkg::PH_DATA:
                    phase_next = (bytes_left_reg == scfd_pkg::LEN_W'(1)) ?
                                 scfd_pkg::PH_END : scfd_pkg::PH_DATA;
                scfd_pkg::PH_END:
                    phase_next = scfd_pkg::PH_START;
                default:
                    phase_next = (rx_byte == scfd_pkg::START_BYTE) ?
                                 scfd_pkg::PH_LEN : scfd_pkg::PH_START;
            endcase
        end
    end

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        id_next         = id_reg;
        length_next     = length_reg;
        data_next       = data_reg;
        out.push        = 1'b0;
        out.frame.id     = id_reg;
        out.frame.length = length_reg;
        out.frame.data   = data_reg;
        if (accept)
        begin
            unique case (phase_reg)
                scfd_pkg::PH_LEN:
                begin
                    length_next = len_nibble;
                    if (!len_bad)
                    begin
                        id_next   = {rx_byte[3:0], 8'h00};
                        data_next = '0;
                    end
                end
                scfd_pkg::PH_IDLO:
                begin
                    id_next         = {id_reg[11:8], rx_byte};
                    bytes_left_next = length_reg;
                end
                scfd_pkg::PH_DATA:
                begin
                    data_next = data_reg |
                        ({{(scfd_pkg::DATA_W-scfd_pkg::BYTE_W){1'b0}}, rx_byte} << {pos, 3'b000});
                    bytes_left_next = bytes_left_reg - 1'b1;
                end
                scfd_pkg::PH_END:
                    out.push = (rx_byte == scfd_pkg::END_BYTE);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= scfd_pkg::PH_START;
            bytes_left_reg <= '0;
            id_reg         <= '0;
            length_reg     <= '0;
            data_reg       <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            id_reg         <= id_next;
            length_reg     <= length_next;
            data_reg       <= data_next;
        end
    end

endmodule

[rtl/scfd_frame_queue.sv]
// Short queue of completed frames between the parser and the filter stage.
module scfd_frame_queue #(
    parameter int DEPTH = scfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  scfd_pkg::frame_push_t in,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output scfd_pkg::frame_t      head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    scfd_pkg::frame_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = in.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= in.frame;
    end

endmodule

[rtl/scfd_filter.sv]
// Acceptance filters and the result register that faces the output side.
module scfd_filter #(
    parameter int NUM_FILTERS = scfd_pkg::NUM_FILTERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [scfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scfd_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                           q_empty,
    input  scfd_pkg::frame_t               q_head,
    output logic                           q_pop,
    input  logic                           pop,
    output logic                           empty,
    output scfd_pkg::frame_t               result,
    output logic [scfd_pkg::HITS_W-1:0]    hits
);

    logic [scfd_pkg::ID_W-1:0]   mask_reg  [NUM_FILTERS];
    logic [scfd_pkg::ID_W-1:0]   match_reg [NUM_FILTERS];
    logic                        valid_reg, valid_next;
    scfd_pkg::frame_t            result_reg;
    logic [scfd_pkg::HITS_W-1:0] hits_reg, hits_next;

    // The result register refills in the same cycle its contents transfer out.
    assign q_pop      = !q_empty && (!valid_reg || pop);
    assign valid_next = q_pop || (valid_reg && !pop);

    always_comb
    begin
        hits_next = '0;
        for (int k = 0; k < NUM_FILTERS; k++)
            hits_next[k] = ((q_head.id & mask_reg[k]) == match_reg[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int k = 0; k < NUM_FILTERS; k++)
            begin
                mask_reg[k]  <= scfd_pkg::MASK_RESET;
                match_reg[k] <= scfd_pkg::MATCH_RESET;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int k = 0; k < NUM_FILTERS; k++)
            begin
                if (cfg_write && cfg_index == scfd_pkg::CFG_IDX_W'(2 * k))
                    mask_reg[k] <= cfg_data;
                if (cfg_write && cfg_index == scfd_pkg::CFG_IDX_W'(2 * k + 1))
                    match_reg[k] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            result_reg <= q_head;
            hits_reg   <= hits_next;
        end
    end

    assign empty  = !valid_reg;
    assign result = result_reg;
    assign hits   = hits_reg;

endmodule

[rtl/serial_can_frame_deframer.sv]
// Top level of the serial CAN frame deframer.
// One received byte is taken per clock whenever full is low; the parser
// handles each accepted byte as it arrives, so a stream of bytes runs at
// one byte per cycle while full stays low. A frame that closes with its end
// byte is written into the frame queue and then moved into the result
// register once that register is free, with its ID already compared against
// the acceptance filters. Up to QUEUE_DEPTH completed frames wait in the frame
// queue behind the result register; full rises while that queue is full, and
// drops on the edge after the consumer pops a result. Filter registers are
// written through the cfg channel, which is always ready; a write to an index
// with no filter behind it is ignored.
`include "serial_can_frame_deframer_defines.svh"

module serial_can_frame_deframer #(
    parameter int NUM_FILTERS    = scfd_pkg::NUM_FILTERS_DEF,
    parameter int MAX_DATA_BYTES = scfd_pkg::MAX_DATA_BYTES_DEF,
    parameter int QUEUE_DEPTH    = scfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [scfd_pkg::BYTE_W-1:0]    rx_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [scfd_pkg::ID_W-1:0]      frame_id,
    output logic [scfd_pkg::LEN_W-1:0]     frame_length,
    output logic [scfd_pkg::DATA_W-1:0]    frame_data,
    output logic [scfd_pkg::HITS_W-1:0]    filter_hits,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [scfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scfd_pkg::CFG_DAT_W-1:0] cfg_data
);

    logic                  byte_accept;
    scfd_pkg::frame_push_t parsed;
    logic                  q_full, q_empty, q_pop;
    scfd_pkg::frame_t      q_head;
    scfd_pkg::frame_t      result;
    logic                  length_ok;
    logic                  tail_clear;

    assign cfg_ready   = 1'b1;
    assign full        = q_full;
    assign byte_accept = push && !q_full;

    scfd_parser #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (byte_accept),
        .rx_byte (rx_byte),
        .out     (parsed)
    );

    scfd_frame_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (parsed),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .head  (q_head)
    );

    scfd_filter #(
        .NUM_FILTERS (NUM_FILTERS)
    ) u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .hits      (filter_hits)
    );

    assign frame_id     = result.id;
    assign frame_length = result.length;
    assign frame_data   = result.data;

    assign length_ok  = frame_length <= scfd_pkg::LEN_W'(MAX_DATA_BYTES);
    assign tail_clear = (frame_data >> {frame_length, 3'b000}) == '0;

    `SCFD_ASSERT_SAME(a_no_push_when_full, parsed.push, !q_full, "frame pushed into full queue")
    `SCFD_ASSERT_SAME(a_length_in_range, !empty, length_ok, "result length above the maximum")
    `SCFD_ASSERT_SAME(a_unused_data_zero, !empty, tail_clear, "unused data bytes are not zero")
    `SCFD_ASSERT_NEXT(a_frame_reaches_queue, parsed.push, !q_empty, "frame not queued")

endmodule

[tb/sv/scfd_frame_checker.sv]
// Frame predictor and result checker for the serial CAN frame deframer.
module scfd_frame_checker
    import scfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [ID_W-1:0]      frame_id,
    input  logic [LEN_W-1:0]     frame_length,
    input  logic [DATA_W-1:0]    frame_data,
    input  logic [HITS_W-1:0]    filter_hits,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   frames_checked
);

    localparam int PRINT_LIMIT = 50;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] data;
        logic [HITS_W-1:0] hits;
    } frame_expect_t;

    frame_expect_t awaited_frames[$];

    logic [ID_W-1:0]   flt_mask  [NUM_FILTERS_DEF];
    logic [ID_W-1:0]   flt_match [NUM_FILTERS_DEF];

    phase_t            phase;
    logic [LEN_W-1:0]  left;
    logic [ID_W-1:0]   id_acc;
    logic [LEN_W-1:0]  len_acc;
    logic [DATA_W-1:0] data_acc;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < PRINT_LIMIT)
        begin
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        end
        fail_count++;
    endtask

    // Advances the parser by one received byte and queues the frame it closes, if any.
    task automatic deframe_byte(input logic [BYTE_W-1:0] c);
        frame_expect_t f;
        logic [2:0]    pos;
        case (phase)
            PH_LEN:
            begin
                len_acc = c[7:4];
                if (len_acc > MAX_DATA_BYTES_DEF)
                begin
                    phase = PH_START;
                end
                else
                begin
                    id_acc   = {c[3:0], 8'h00};
                    data_acc = '0;
                    phase    = PH_IDLO;
                end
            end
            PH_IDLO:
            begin
                id_acc = id_acc | {4'h0, c};
                left   = len_acc;
                phase  = (left == 0) ? PH_END : PH_DATA;
            end
            PH_DATA:
            begin
                pos      = 3'(len_acc - left);
                data_acc = data_acc | ({56'd0, c} << (8 * pos));
                left     = left - 1'b1;
                if (left == 0)
                begin
                    phase = PH_END;
                end
            end
            PH_END:
            begin
                // A wrong end byte only drops the frame; it never starts a new one.
                phase = PH_START;
                if (c == END_BYTE)
                begin
                    f.id     = id_acc;
                    f.length = len_acc;
                    f.data   = data_acc;
                    f.hits   = '0;
                    for (int k = 0; k < NUM_FILTERS_DEF; k++)
                    begin
                        if ((id_acc & flt_mask[k]) == flt_match[k])
                        begin
                            f.hits[k] = 1'b1;
                        end
                    end
                    awaited_frames.insert(awaited_frames.size(), f);
                end
            end
            default:
            begin
                phase = (c == START_BYTE) ? PH_LEN : PH_START;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_expect_t f;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_FILTERS_DEF; k++)
            begin
                flt_mask[k]  = MASK_RESET;
                flt_match[k] = MATCH_RESET;
            end
            phase          = PH_START;
            left           = '0;
            id_acc         = '0;
            len_acc        = '0;
            data_acc       = '0;
            fail_count     = 0;
            frames_checked = 0;
            awaited_frames.delete();
        end
        else
        begin
            // Results are checked before this edge's byte is parsed, so a frame
            // closed now can never be matched against a result already waiting.
            if (pop && !empty)
            begin
                if (awaited_frames.size() == 0)
                begin
                    report_mismatch("result with no frame awaited, id", frame_id, '0);
                end
                else
                begin
                    f = awaited_frames.pop_front();
                    if (frame_id !== f.id)
                    begin
                        report_mismatch("frame_id", frame_id, f.id);
                    end
                    if (frame_length !== f.length)
                    begin
                        report_mismatch("frame_length", frame_length, f.length);
                    end
                    if (frame_data !== f.data)
                    begin
                        report_mismatch("frame_data", frame_data, f.data);
                    end
                    if (filter_hits !== f.hits)
                    begin
                        report_mismatch("filter_hits", filter_hits, f.hits);
                    end
                    frames_checked++;
                end
            end
            if (cfg_valid && cfg_ready && cfg_index < 2 * NUM_FILTERS_DEF)
            begin
                if (cfg_index[0])
                begin
                    flt_match[cfg_index[2:1]] = cfg_data;
                end
                else
                begin
                    flt_mask[cfg_index[2:1]] = cfg_data;
                end
            end
            if (push && !full)
            begin
                deframe_byte(rx_byte);
            end
        end
        pending = awaited_frames.size();
    end

endmodule

[tb/sv/tb.sv]
// Top of the serial CAN frame deframer testbench: clock, reset, stimulus and verdict.
module tb;
    import scfd_pkg::*;

    localparam int ITEM_TARGET    = 1100;
    localparam int NUM_SETTINGS   = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int CALM_FROM      = 600;
    localparam int CALM_TO        = 1000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic [BYTE_W-1:0]    rx_byte   = '0;
    logic                 pop       = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    logic                 full;
    logic                 empty;
    logic                 cfg_ready;
    logic [ID_W-1:0]      frame_id;
    logic [LEN_W-1:0]     frame_length;
    logic [DATA_W-1:0]    frame_data;
    logic [HITS_W-1:0]    filter_hits;

    int fail_count;
    int pending;
    int frames_checked;
    int bytes_sent   = 0;
    int cfg_writes   = 0;
    int cycle_no     = 0;
    int quiet_cycles = 0;

    // Copies of the filter settings, used only to steer IDs towards hits.
    logic [ID_W-1:0] cur_mask  [NUM_FILTERS_DEF] = '{default: MASK_RESET};
    logic [ID_W-1:0] cur_match [NUM_FILTERS_DEF] = '{default: MATCH_RESET};

    wire calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

    always #5 clk = ~clk;

    serial_can_frame_deframer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .frame_id     (frame_id),
        .frame_length (frame_length),
        .frame_data   (frame_data),
        .filter_hits  (filter_hits),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    scfd_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .frame_id       (frame_id),
        .frame_length   (frame_length),
        .frame_data     (frame_data),
        .filter_hits    (filter_hits),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .frames_checked (frames_checked)
    );

    // The consumer stalls at random, except through the calm window.
    always @(negedge clk)
    begin
        pop <= calm || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge clk)
    begin
        cycle_no++;
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d frames outstanding",
                     quiet_cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [3:0] len_nib, input logic [ID_W-1:0] id,
                              input logic [DATA_W-1:0] data, input logic [BYTE_W-1:0] tail);
        send_byte(START_BYTE);
        send_byte({len_nib, id[11:8]});
        if (len_nib > MAX_DATA_BYTES_DEF)
        begin
            return;
        end
        send_byte(id[7:0]);
        for (int i = 0; i < len_nib; i++)
        begin
            send_byte(data[8*i +: 8]);
        end
        send_byte(tail);
    endtask

    // Holds the input off until every predicted frame has been transferred out.
    task automatic drain_results();
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_writes++;
        if (idx < 2 * NUM_FILTERS_DEF)
        begin
            if (idx[0])
            begin
                cur_match[idx[2:1]] = val;
            end
            else
            begin
                cur_mask[idx[2:1]] = val;
            end
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int setting);
        logic [ID_W-1:0] m;
        logic [ID_W-1:0] v;
        for (int k = 0; k < NUM_FILTERS_DEF; k++)
        begin
            case (setting)
                0:
                begin
                    m = '0;
                    v = '0;
                end
                1:
                begin
                    m = '1;
                    v = '1;
                end
                2:
                begin
                    m = '1;
                    v = '0;
                end
                default:
                begin
                    m = 12'($urandom);
                    v = ($urandom_range(0, 3) == 0) ? 12'($urandom) : (12'($urandom) & m);
                end
            endcase
            write_reg(4'(2 * k), m);
            write_reg(4'(2 * k + 1), v);
        end
        // Indexes with no filter behind them must leave the filters untouched.
        repeat ($urandom_range(1, 2)) write_reg(4'($urandom_range(8, 15)), 12'($urandom));
    endtask

    initial
    begin
        int                kind;
        int                phase_goal;
        int                k;
        logic [3:0]        len;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
        logic [BYTE_W-1:0] tail;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset filter settings.
        send_frame(4'd0, 12'h000, '0, END_BYTE);
        send_frame(4'd8, 12'hFFF, 64'h7FFE_AA55_8001_FF00, END_BYTE);
        send_frame(4'hF, 12'h5A5, '0, END_BYTE);
        // A start byte in the end position drops the frame and is not taken as a new
        // start, so the bytes after it must not form a frame.
        send_frame(4'd0, 12'h123, '0, START_BYTE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(END_BYTE);

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            drain_results();
            configure(p);
            phase_goal = bytes_sent + ITEM_TARGET / NUM_SETTINGS;
            while (bytes_sent < phase_goal)
            begin
                kind = $urandom_range(0, 99);
                len  = 4'($urandom_range(0, MAX_DATA_BYTES_DEF));
                id   = 12'($urandom);
                data = {$urandom, $urandom};
                if ($urandom_range(0, 1) == 1)
                begin
                    k  = $urandom_range(0, NUM_FILTERS_DEF - 1);
                    id = cur_match[k] | (id & ~cur_mask[k]);
                end
                if (kind < 72)
                begin
                    send_frame(len, id, data, END_BYTE);
                end
                else if (kind < 80)
                begin
                    send_frame(4'($urandom_range(MAX_DATA_BYTES_DEF + 1, 15)), id, data,
                               END_BYTE);
                end
                else if (kind < 88)
                begin
                    tail = ($urandom_range(0, 2) == 0) ? START_BYTE : 8'($urandom);
                    if (tail == END_BYTE)
                    begin
                        tail = START_BYTE;
                    end
                    send_frame(len, id, data, tail);
                end
                else if (kind < 95)
                begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
                else
                begin
                    // A frame cut short: the next start byte lands inside it.
                    send_byte(START_BYTE);
                    send_byte({len, id[11:8]});
                end
                if ($urandom_range(0, 99) < 2)
                begin
                    drain_results();
                end
            end
        end

        drain_results();
        $display("covered %0d bytes in, %0d frames checked, %0d register writes",
                 bytes_sent, frames_checked, cfg_writes);
        $display("filter settings used: reset values and %0d others, extremes among them",
                 NUM_SETTINGS);
        if (fail_count == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
